// ===== rtl/ecpm_pkg.sv =====
// Shared types and codes for the elliptic-curve point add / scalar multiply core.
// No dependencies.
package ecpm_pkg;

  // Operation codes carried in the cmd field.
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_MUL = 1'b1;

  // Configuration register indexes.
  localparam logic REG_CURVE_A     = 1'b0;
  localparam logic REG_FIELD_PRIME = 1'b1;

  // Handshake between the sequencer and a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_ADD_START,
    ST_TAN_GO,
    ST_TAN_WAIT,
    ST_TAN_3,
    ST_TAN_3B,
    ST_TAN_A,
    ST_EU_TEST,
    ST_EU_DIV_WAIT,
    ST_EU_MUL_GO,
    ST_EU_MUL_WAIT,
    ST_SL_GO,
    ST_SL_WAIT,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_X_2,
    ST_Y_GO,
    ST_Y_WAIT,
    ST_ADD_END,
    ST_DONE
  } state_e;

endpackage

// ===== rtl/ecpm_if.sv =====
// Channel interfaces of the point core: input items, results, configuration writes.
// No dependencies.
interface ecpm_in_if #(
  parameter int FIELD_BITS  = 16,
  parameter int SCALAR_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [FIELD_BITS-1:0]  first_x;
  logic [FIELD_BITS-1:0]  first_y;
  logic                   first_inf;
  logic [FIELD_BITS-1:0]  second_x;
  logic [FIELD_BITS-1:0]  second_y;
  logic                   second_inf;
  logic [SCALAR_BITS-1:0] scalar;

  modport source (output valid, cmd, first_x, first_y, first_inf, second_x, second_y,
                  second_inf, scalar, input ready);
  modport sink (input valid, cmd, first_x, first_y, first_inf, second_x, second_y,
                second_inf, scalar, output ready);
endinterface

interface ecpm_out_if #(
  parameter int FIELD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] result_x;
  logic [FIELD_BITS-1:0] result_y;
  logic                  result_inf;

  modport source (output valid, result_x, result_y, result_inf, input ready);
  modport sink (input valid, result_x, result_y, result_inf, output ready);
endinterface

interface ecpm_cfg_if #(
  parameter int DATA_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 index;
  logic [DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ecpm_modmul.sv =====
// Bit-serial modular multiplier: (mplier * mcand) mod p, one multiplier bit per cycle.
// Depends on ecpm_pkg. mcand must already be below p.
module ecpm_modmul #(
  parameter int FB = 16,
  parameter int MW = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [MW-1:0]            mplier_i,
  input  logic [FB-1:0]            mcand_i,
  input  logic [FB-1:0]            mod_i,
  output ecpm_pkg::unit_stat_t     stat_o,
  output logic [FB-1:0]            res_o
);
  import ecpm_pkg::*;

  localparam int CW = $clog2(MW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [MW-1:0] shr_q, shr_d;
  logic [FB-1:0] acc_q, acc_d, mcand_q, mcand_d, mod_q, mod_d;
  logic [FB+1:0] sum, p1, p2;

  // acc = 2*acc + bit*mcand, below 3p, brought back under p
  always_comb begin
    sum = {1'b0, acc_q, 1'b0} + (shr_q[MW-1] ? {2'b0, mcand_q} : '0);
    p1  = {2'b0, mod_q};
    p2  = {1'b0, mod_q, 1'b0};
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    shr_d   = shr_q;
    acc_d   = acc_q;
    mcand_d = mcand_q;
    mod_d   = mod_q;
    if (start_i) begin
      cnt_d   = CW'(MW);
      shr_d   = mplier_i;
      acc_d   = '0;
      mcand_d = mcand_i;
      mod_d   = mod_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      shr_d = shr_q << 1;
      if (sum >= p2) begin
        acc_d = FB'(sum - p2);
      end else if (sum >= p1) begin
        acc_d = FB'(sum - p1);
      end else begin
        acc_d = FB'(sum);
      end
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shr_q   <= shr_d;
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mod_q   <= mod_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign res_o       = acc_q;

endmodule

// ===== rtl/ecpm_div.sv =====
// Restoring serial divider: quotient and remainder, one quotient bit per cycle.
// Depends on ecpm_pkg. Divisor must be nonzero.
module ecpm_div #(
  parameter int FB = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FB-1:0]        dividend_i,
  input  logic [FB-1:0]        divisor_i,
  output ecpm_pkg::unit_stat_t stat_o,
  output logic [FB-1:0]        quot_o,
  output logic [FB-1:0]        rem_o
);
  import ecpm_pkg::*;

  localparam int CW = $clog2(FB + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          done_q, done_d;
  logic [FB-1:0] dvd_q, dvd_d, dsr_q, dsr_d, rem_q, rem_d, quo_q, quo_d;
  logic [FB:0]   trial;
  logic          ge;

  always_comb begin
    trial  = {rem_q, dvd_q[FB-1]};
    ge     = (trial >= {1'b0, dsr_q});
    cnt_d  = cnt_q;
    done_d = 1'b0;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d = CW'(FB);
      dvd_d = dividend_i;
      dsr_d = divisor_i;
      rem_d = '0;
      quo_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      dvd_d  = dvd_q << 1;
      rem_d  = ge ? FB'(trial - {1'b0, dsr_q}) : FB'(trial);
      quo_d  = {quo_q[FB-2:0], ge};
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;
  assign rem_o       = rem_q;

endmodule

// ===== rtl/ec_point_add_scalar_mult_core.sv =====
// Top level: affine point add / double-and-add scalar multiply over GF(p).
// Depends on ecpm_pkg, ecpm_if, ecpm_modmul, ecpm_div.
//
//  channel | dir | beat fields
//  --------+-----+--------------------------------------------------------------
//  in_i    | in  | cmd, first_x/y/inf, second_x/y/inf, scalar
//  out_o   | out | result_x, result_y, result_inf
//  cfg_i   | in  | index (0 curve_a, 1 field_prime), data
//
//  One item at a time; in_i.ready is high only while the sequencer is idle.
//  Cost is set by the serial multiplier (MW = max(FIELD_BITS,16)), shared by
//  every reduction and multiply, and the divider used by Euclid. Each item first runs
//  5 (add) or 3 (multiply) reductions; a point add then takes 3 (chord) or 4
//  (tangent) multiplies plus one Euclid pass of up to ~1.5*FIELD_BITS rounds, each
//  one divide and one multiply; a scalar multiply runs up to 2*SCALAR_BITS point
//  adds. A finished result waits in out_o while the next beat is taken. Reset
//  loads curve_a = -3, field_prime = 139; no memory.
module ec_point_add_scalar_mult_core #(
  parameter int FIELD_BITS  = 16,
  parameter int SCALAR_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ecpm_in_if.sink    in_i,
  ecpm_out_if.source out_o,
  ecpm_cfg_if.sink   cfg_i
);
  import ecpm_pkg::*;

  localparam int FB  = FIELD_BITS;
  localparam int SB  = SCALAR_BITS;
  localparam int MW  = (FB > 16) ? FB : 16;
  localparam int BLW = $clog2(SB + 1);

  function automatic logic [FB-1:0] mod_add(input logic [FB-1:0] x, input logic [FB-1:0] y,
                                            input logic [FB-1:0] m);
    logic [FB:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= {1'b0, m}) ? FB'(s - {1'b0, m}) : FB'(s);
  endfunction

  function automatic logic [FB-1:0] mod_sub(input logic [FB-1:0] x, input logic [FB-1:0] y,
                                            input logic [FB-1:0] m);
    return (x >= y) ? FB'(x - y) : FB'(x - y + m);
  endfunction

  state_e state_q, state_d;

  // configuration
  logic [15:0]   ca_q;
  logic [FB-1:0] fp_q;

  // item registers
  logic           cmd_q, out_valid_q;
  logic [FB-1:0]  raw_fx_q, raw_fy_q, raw_sx_q, raw_sy_q;
  logic           sinf_q, pinf_q, qinf_q, rinf_q;
  logic [SB-1:0]  k_q;
  logic [BLW-1:0] bits_left_q;
  logic           phase_q;
  logic [2:0]     red_sel_q;
  logic [FB-1:0]  a_q, px_q, py_q, qx_q, qy_q, rx_q, ry_q;
  logic [FB-1:0]  num_q, tx_q, slope_q;
  logic [FB-1:0]  r0_q, r1_q, t0_q, t1_q, quo_q, rn_q;
  logic [FB-1:0]  ox_q, oy_q;
  logic           oinf_q;

  // serial units
  logic          mul_start, div_start;
  logic [MW-1:0] mul_a;
  logic [FB-1:0] mul_b, mul_res, div_quo, div_rem;
  unit_stat_t    mul_st, div_st;

  logic          in_fire, red_last, distinct, out_load;
  logic [15:0]   a_mag;

  assign in_fire  = in_i.valid && in_i.ready;
  assign red_last = (red_sel_q == 3'd4) || (cmd_q == CMD_MUL && red_sel_q == 3'd2);
  assign distinct = (rx_q != qx_q) || (ry_q != qy_q);
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
  // magnitude of a negative curve_a, reduced then negated mod p
  assign a_mag    = ca_q[15] ? (~ca_q + 16'd1) : ca_q;

  ecpm_modmul #(.FB(FB), .MW(MW)) u_mul (
    .clk_i, .rst_ni,
    .start_i  (mul_start),
    .mplier_i (mul_a),
    .mcand_i  (mul_b),
    .mod_i    (fp_q),
    .stat_o   (mul_st),
    .res_o    (mul_res)
  );

  ecpm_div #(.FB(FB)) u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (r0_q),
    .divisor_i  (r1_q),
    .stat_o     (div_st),
    .quot_o     (div_quo),
    .rem_o      (div_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:        if (in_fire) state_d = (fp_q < FB'(2)) ? ST_DONE : ST_RED_GO;
      ST_RED_GO:      state_d = ST_RED_WAIT;
      ST_RED_WAIT:    if (mul_st.done) state_d = red_last ? ST_ADD_START : ST_RED_GO;
      ST_ADD_START: begin
        if (rinf_q || qinf_q) state_d = ST_ADD_END;
        else if (distinct)    state_d = ST_EU_TEST;
        else                  state_d = ST_TAN_GO;
      end
      ST_TAN_GO:      state_d = ST_TAN_WAIT;
      ST_TAN_WAIT:    if (mul_st.done) state_d = ST_TAN_3;
      ST_TAN_3:       state_d = ST_TAN_3B;
      ST_TAN_3B:      state_d = ST_TAN_A;
      ST_TAN_A:       state_d = ST_EU_TEST;
      ST_EU_TEST: begin
        if (r1_q != '0)          state_d = ST_EU_DIV_WAIT;
        else if (r0_q == FB'(1)) state_d = ST_SL_GO;
        else                     state_d = ST_ADD_END;
      end
      ST_EU_DIV_WAIT: if (div_st.done) state_d = ST_EU_MUL_GO;
      ST_EU_MUL_GO:   state_d = ST_EU_MUL_WAIT;
      ST_EU_MUL_WAIT: if (mul_st.done) state_d = ST_EU_TEST;
      ST_SL_GO:       state_d = ST_SL_WAIT;
      ST_SL_WAIT:     if (mul_st.done) state_d = ST_SQ_GO;
      ST_SQ_GO:       state_d = ST_SQ_WAIT;
      ST_SQ_WAIT:     if (mul_st.done) state_d = ST_X_2;
      ST_X_2:         state_d = ST_Y_GO;
      ST_Y_GO:        state_d = ST_Y_WAIT;
      ST_Y_WAIT:      if (mul_st.done) state_d = ST_ADD_END;
      ST_ADD_END: begin
        if (cmd_q == CMD_ADD)                    state_d = ST_DONE;
        else if (!phase_q && k_q[SB-1])          state_d = ST_ADD_START;
        else if (bits_left_q == BLW'(1))         state_d = ST_DONE;
        else                                     state_d = ST_ADD_START;
      end
      ST_DONE:        if (out_load) state_d = ST_IDLE;
      default:        state_d = ST_IDLE;
    endcase
  end

  // unit starts and operand selection
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_q)
      ST_RED_GO: begin
        // x * 1 mod p reduces an unreduced operand
        mul_start = 1'b1;
        mul_b     = FB'(1);
        case (red_sel_q)
          3'd0:    mul_a = MW'(a_mag);
          3'd1:    mul_a = MW'(raw_fx_q);
          3'd2:    mul_a = MW'(raw_fy_q);
          3'd3:    mul_a = MW'(raw_sx_q);
          default: mul_a = MW'(raw_sy_q);
        endcase
      end
      ST_TAN_GO: begin
        mul_start = 1'b1;
        mul_a     = MW'(rx_q);
        mul_b     = rx_q;
      end
      ST_EU_TEST:   div_start = (r1_q != '0);
      ST_EU_MUL_GO: begin
        mul_start = 1'b1;
        mul_a     = MW'(quo_q);
        mul_b     = t1_q;
      end
      ST_SL_GO: begin
        mul_start = 1'b1;
        mul_a     = MW'(num_q);
        mul_b     = t0_q;
      end
      ST_SQ_GO: begin
        mul_start = 1'b1;
        mul_a     = MW'(slope_q);
        mul_b     = slope_q;
      end
      ST_Y_GO: begin
        mul_start = 1'b1;
        mul_a     = MW'(slope_q);
        mul_b     = mod_sub(rx_q, tx_q, fp_q);
      end
      default: ;
    endcase
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_valid_q;
  assign out_o.result_x   = ox_q;
  assign out_o.result_y   = oy_q;
  assign out_o.result_inf = oinf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ca_q        <= 16'hFFFD;
      fp_q        <= FB'(139);
    end else begin
      state_q <= state_d;
      if (out_load)          out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          REG_CURVE_A:     ca_q <= cfg_i.data[15:0];
          REG_FIELD_PRIME: fp_q <= cfg_i.data[FB-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (in_fire) begin
        cmd_q     <= in_i.cmd;
        raw_fx_q  <= in_i.first_x;
        raw_fy_q  <= in_i.first_y;
        pinf_q    <= in_i.first_inf;
        raw_sx_q  <= in_i.second_x;
        raw_sy_q  <= in_i.second_y;
        sinf_q    <= in_i.second_inf;
        k_q       <= in_i.scalar;
        red_sel_q <= '0;
        rinf_q    <= 1'b1;
        rx_q      <= '0;
        ry_q      <= '0;
      end
      ST_RED_WAIT: if (mul_st.done) begin
        red_sel_q <= red_sel_q + 3'd1;
        case (red_sel_q)
          3'd0:    a_q  <= (ca_q[15] && mul_res != '0) ? fp_q - mul_res : mul_res;
          3'd1:    px_q <= mul_res;
          3'd2:    py_q <= mul_res;
          3'd3:    qx_q <= mul_res;
          default: qy_q <= mul_res;
        endcase
        if (red_last) begin
          if (cmd_q == CMD_ADD) begin
            rx_q   <= px_q;
            ry_q   <= py_q;
            rinf_q <= pinf_q;
            qinf_q <= sinf_q;
          end else begin
            // double-and-add from infinity; first step doubles R
            rinf_q      <= 1'b1;
            qinf_q      <= 1'b1;
            bits_left_q <= BLW'(SB);
            phase_q     <= 1'b0;
          end
        end
      end
      ST_ADD_START: begin
        if (rinf_q) begin
          rx_q   <= qx_q;
          ry_q   <= qy_q;
          rinf_q <= qinf_q;
        end else if (!qinf_q && distinct) begin
          // chord slope
          num_q <= mod_sub(qy_q, ry_q, fp_q);
          r0_q  <= fp_q;
          r1_q  <= mod_sub(qx_q, rx_q, fp_q);
          t0_q  <= '0;
          t1_q  <= FB'(1);
        end
      end
      ST_TAN_WAIT: if (mul_st.done) tx_q <= mul_res;
      ST_TAN_3:  num_q <= mod_add(tx_q, tx_q, fp_q);
      ST_TAN_3B: num_q <= mod_add(num_q, tx_q, fp_q);
      ST_TAN_A: begin
        // tangent slope: (3x^2 + a) / 2y
        num_q <= mod_add(num_q, a_q, fp_q);
        r0_q  <= fp_q;
        r1_q  <= mod_add(ry_q, ry_q, fp_q);
        t0_q  <= '0;
        t1_q  <= FB'(1);
      end
      ST_EU_TEST: if (r1_q == '0 && r0_q != FB'(1)) rinf_q <= 1'b1;
      ST_EU_DIV_WAIT: if (div_st.done) begin
        quo_q <= div_quo;
        rn_q  <= div_rem;
      end
      ST_EU_MUL_WAIT: if (mul_st.done) begin
        // Bezout coefficient kept reduced mod p
        t1_q <= mod_sub(t0_q, mul_res, fp_q);
        t0_q <= t1_q;
        r0_q <= r1_q;
        r1_q <= rn_q;
      end
      ST_SL_WAIT: if (mul_st.done) slope_q <= mul_res;
      ST_SQ_WAIT: if (mul_st.done) tx_q <= mod_sub(mul_res, rx_q, fp_q);
      ST_X_2:     tx_q <= mod_sub(tx_q, qx_q, fp_q);
      ST_Y_WAIT: if (mul_st.done) begin
        ry_q   <= mod_sub(mul_res, ry_q, fp_q);
        rx_q   <= tx_q;
        rinf_q <= 1'b0;
      end
      ST_ADD_END: if (cmd_q == CMD_MUL) begin
        if (!phase_q && k_q[SB-1]) begin
          qx_q    <= px_q;
          qy_q    <= py_q;
          qinf_q  <= pinf_q;
          phase_q <= 1'b1;
        end else begin
          k_q         <= k_q << 1;
          bits_left_q <= bits_left_q - 1'b1;
          phase_q     <= 1'b0;
          qx_q        <= rx_q;
          qy_q        <= ry_q;
          qinf_q      <= rinf_q;
        end
      end
      ST_DONE: if (out_load) begin
        ox_q   <= rinf_q ? '0 : rx_q;
        oy_q   <= rinf_q ? '0 : ry_q;
        oinf_q <= rinf_q;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_st.busy)
    else $error("multiplier started while busy");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (r1_q != '0) && !div_st.busy)
    else $error("divider started with zero divisor or while busy");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("second beat taken while an item is in flight");

  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_inf) |-> (out_o.result_x == '0 && out_o.result_y == '0))
    else $error("infinite result with nonzero coordinates");
`endif

endmodule
